// ===== hw/rtl/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// Tricorn escape-time package
// Shared widths, register indexes, reset values, record types and the
// Q4.28 saturation helper used by the front end and the iteration engine.
// ----------------------------------------------------------------------------
package tce_pkg;

    // Field widths
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int Q_W        = 32;
    localparam int STEP_W     = 31;
    localparam int CNT_W      = 16;
    localparam int FRAC_BITS  = 28;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_IM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd4;

    localparam logic [STEP_W-1:0] STEP_RESET   = 31'd1048576;
    localparam logic [Q_W-1:0]    OFFSET_RESET = 32'd0;
    localparam logic [CNT_W-1:0]  LIMIT_RESET  = 16'd50;

    // Wide intermediate width for saturation
    localparam int SAT_W = 48;

    // Squared-part width: floor(x*x / 2^28) with |x| <= 2^31
    localparam int SQ_W = 2*Q_W - 1 - FRAC_BITS;
    // Cross-term width: floor(x*y / 2^27)
    localparam int XY_W = 2*Q_W - FRAC_BITS + 1;

    // Job queue between front end and engine
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [STEP_W-1:0] step_re;
        logic [STEP_W-1:0] step_im;
        logic [Q_W-1:0]    offset_re;
        logic [Q_W-1:0]    offset_im;
        logic [CNT_W-1:0]  iter_limit;
    } tce_cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [Q_W-1:0]   c_re;
        logic [Q_W-1:0]   c_im;
    } tce_job_t;

    typedef struct packed {
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic [CNT_W-1:0] iteration_count;
        logic             escaped;
    } tce_result_t;

    // Clamp a wide signed value to the Q4.28 range
    function automatic logic [Q_W-1:0] sat_q(input logic [SAT_W-1:0] v);
        logic in_range;
        in_range = (v[SAT_W-1:Q_W-1] == {(SAT_W-Q_W+1){v[SAT_W-1]}});
        if (in_range)
        begin
            return v[Q_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            return {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== hw/rtl/tce_if.sv =====
// ----------------------------------------------------------------------------
// Tricorn escape-time channel interfaces
// Valid/ready channels for pixel input, result output and register writes.
// ----------------------------------------------------------------------------
interface tce_pixel_if import tce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface tce_result_if import tce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [CNT_W-1:0] iteration_count;
    logic             escaped;

    modport source (output valid, output out_col, output out_row,
                    output iteration_count, output escaped, input ready);
    modport sink   (input valid, input out_col, input out_row,
                    input iteration_count, input escaped, output ready);
endinterface

interface tce_cfg_if import tce_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tce_queue.sv =====
// ----------------------------------------------------------------------------
// Tricorn job queue
// Short register queue that decouples the coordinate front end from the
// iteration engine.
// ----------------------------------------------------------------------------
module tce_queue import tce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  tce_job_t push_data,
    input  logic     pop,
    output tce_job_t pop_data,
    output logic     full,
    output logic     empty
);

    tce_job_t           entry_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]     count_reg, count_next;

    assign full     = (count_reg == QCW'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/tce_front.sv =====
// ----------------------------------------------------------------------------
// Tricorn coordinate front end
// Accepts pixels, multiplies the centered pixel index by the step, then adds
// the pan with saturation and pushes the complex point into the job queue.
// ----------------------------------------------------------------------------
module tce_front import tce_pkg::*;
#(
    parameter int WIDTH  = 1024,
    parameter int HEIGHT = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tce_cfg_t          cfg_q,
    tce_pixel_if.sink         pixel,
    input  logic              q_full,
    output logic              q_push,
    output tce_job_t          q_data
);

    localparam int HALF_W = WIDTH / 2;
    localparam int HALF_H = HEIGHT / 2;
    localparam int COL_MAX = (1 << COL_W) - 1;
    localparam int ROW_MAX = (1 << ROW_W) - 1;
    // Signed width that holds col - WIDTH/2 and row - HEIGHT/2
    localparam int DC_W = $clog2(((HALF_W > COL_MAX) ? HALF_W : COL_MAX) + 1) + 1;
    localparam int DR_W = $clog2(((HALF_H > ROW_MAX) ? HALF_H : ROW_MAX) + 1) + 1;
    localparam int PC_W = DC_W + Q_W;
    localparam int PR_W = DR_W + Q_W;

    logic                    s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic signed [PC_W-1:0]  prod_re_reg;
    logic signed [PR_W-1:0]  prod_im_reg;

    logic                    accept;
    logic signed [DC_W-1:0]  dc;
    logic signed [DR_W-1:0]  dr;
    logic signed [PC_W-1:0]  prod_re;
    logic signed [PR_W-1:0]  prod_im;
    logic [SAT_W-1:0]        sum_re;
    logic [SAT_W-1:0]        sum_im;

    // Stage 1 is free when empty or draining into the queue this cycle
    assign q_push      = s1_valid_reg && !q_full;
    assign pixel.ready = !s1_valid_reg || !q_full;
    assign accept      = pixel.valid && pixel.ready;

    // Centered pixel index times step
    assign dc = $signed({{(DC_W-COL_W){1'b0}}, pixel.pixel_col}) - $signed(DC_W'(HALF_W));
    assign dr = $signed({{(DR_W-ROW_W){1'b0}}, pixel.pixel_row}) - $signed(DR_W'(HALF_H));

    assign prod_re = $signed({{(PC_W-DC_W){dc[DC_W-1]}}, dc})
                   * $signed({{(PC_W-STEP_W){1'b0}}, cfg_q.step_re});
    assign prod_im = $signed({{(PR_W-DR_W){dr[DR_W-1]}}, dr})
                   * $signed({{(PR_W-STEP_W){1'b0}}, cfg_q.step_im});

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg     <= pixel.pixel_col;
            row_reg     <= pixel.pixel_row;
            prod_re_reg <= prod_re;
            prod_im_reg <= prod_im;
        end
    end

    // Stage 2: add pan and clamp to Q4.28
    assign sum_re = $signed({{(SAT_W-PC_W){prod_re_reg[PC_W-1]}}, prod_re_reg})
                  + $signed({{(SAT_W-Q_W){cfg_q.offset_re[Q_W-1]}}, cfg_q.offset_re});
    assign sum_im = $signed({{(SAT_W-PR_W){prod_im_reg[PR_W-1]}}, prod_im_reg})
                  + $signed({{(SAT_W-Q_W){cfg_q.offset_im[Q_W-1]}}, cfg_q.offset_im});

    assign q_data.col  = col_reg;
    assign q_data.row  = row_reg;
    assign q_data.c_re = sat_q(sum_re);
    assign q_data.c_im = sat_q(sum_im);

endmodule

// ===== hw/rtl/tce_engine.sv =====
// ----------------------------------------------------------------------------
// Tricorn iteration engine
// Pops one point, iterates z = conj(z)^2 + c with each step split into a
// multiply state and an escape test and update state, and holds the result
// in an output register.
// ----------------------------------------------------------------------------
module tce_engine import tce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tce_cfg_t    cfg_q,
    input  logic        job_valid,
    input  tce_job_t    job,
    output logic        job_pop,
    output logic        res_valid,
    input  logic        res_ready,
    output tce_result_t res,
    output logic        busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    // 4.0 in the squared-magnitude format
    localparam logic [SQ_W:0] ESC_LIM =
        {{(SQ_W-FRAC_BITS-2){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;
    tce_result_t              out_reg, out_next;
    logic signed [Q_W-1:0]    x_reg, x_next;
    logic signed [Q_W-1:0]    y_reg, y_next;
    logic [Q_W-1:0]           cre_reg, cre_next;
    logic [Q_W-1:0]           cim_reg, cim_next;
    logic [COL_W-1:0]         col_reg, col_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic signed [2*Q_W-1:0]  pxx_reg, pyy_reg, pxy_reg;

    logic [SQ_W-1:0]          sx, sy;
    logic [SQ_W:0]            mag;
    logic                     under_limit;
    logic                     keep_going;
    logic                     out_free;
    logic [SAT_W-1:0]         nx_wide, ny_wide;
    tce_result_t              finished;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign busy      = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || res_ready;

    // Escape test and next iterate
    assign sx          = pxx_reg[2*Q_W-2:FRAC_BITS];
    assign sy          = pyy_reg[2*Q_W-2:FRAC_BITS];
    assign mag         = {1'b0, sx} + {1'b0, sy};
    assign under_limit = (count_reg < cfg_q.iter_limit);
    assign keep_going  = (mag < ESC_LIM) && under_limit;

    assign nx_wide = $signed({{(SAT_W-SQ_W){1'b0}}, sx})
                   - $signed({{(SAT_W-SQ_W){1'b0}}, sy})
                   + $signed({{(SAT_W-Q_W){cre_reg[Q_W-1]}}, cre_reg});
    assign ny_wide = $signed({{(SAT_W-Q_W){cim_reg[Q_W-1]}}, cim_reg})
                   - $signed({{(SAT_W-XY_W){pxy_reg[2*Q_W-1]}},
                              pxy_reg[2*Q_W-1:FRAC_BITS-1]});

    assign finished.out_col         = col_reg;
    assign finished.out_row         = row_reg;
    assign finished.iteration_count = count_reg;
    assign finished.escaped         = under_limit;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cre_next       = cre_reg;
        cim_next       = cim_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        job_pop        = 1'b0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    col_next   = job.col;
                    row_next   = job.row;
                    cre_next   = job.c_re;
                    cim_next   = job.c_im;
                    x_next     = '0;
                    y_next     = '0;
                    count_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (keep_going)
                begin
                    x_next     = sat_q(nx_wide);
                    y_next     = sat_q(ny_wide);
                    count_next = count_reg + 1'b1;
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    out_next       = finished;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = finished;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and product registers
    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        out_reg   <= out_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        cre_reg   <= cre_next;
        cim_reg   <= cim_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        pxx_reg   <= x_reg * x_reg;
        pyy_reg   <= y_reg * y_reg;
        pxy_reg   <= x_reg * y_reg;
    end

endmodule

// ===== hw/rtl/tricorn_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// Tricorn escape-time core
// A pixel passes through the coordinate front-end register and the job
// queue into the iteration engine, which pops it from its idle state. For
// each iteration counted in the result (at most the iteration limit), the
// engine forms the three 32x32 products in the multiply state and makes the
// escape test and update in the update state; a final multiply and escape
// test end the point and load the result register. The engine pops its next
// point in the cycle after loading a result, so it finishes one point before
// taking another and sets the rate. A two-entry job queue lets the front end take new pixels
// while the engine works, and the result register lets the engine start the
// next pixel while a result waits. Registers must be written only while the
// core is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module tricorn_escape_time_core import tce_pkg::*;
#(
    parameter int WIDTH  = 1024,
    parameter int HEIGHT = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    tce_pixel_if.sink     pixel,
    tce_result_if.source  result,
    tce_cfg_if.sink       cfg
);

    tce_cfg_t    cfg_reg, cfg_next;
    logic        q_push, q_pop, q_full, q_empty;
    tce_job_t    q_in, q_out;
    tce_result_t res;
    logic        eng_busy;

    // Register file writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_STEP_RE:    cfg_next.step_re    = cfg.data[STEP_W-1:0];
                CFG_STEP_IM:    cfg_next.step_im    = cfg.data[STEP_W-1:0];
                CFG_OFFSET_RE:  cfg_next.offset_re  = cfg.data[Q_W-1:0];
                CFG_OFFSET_IM:  cfg_next.offset_im  = cfg.data[Q_W-1:0];
                CFG_ITER_LIMIT: cfg_next.iter_limit = cfg.data[CNT_W-1:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_re    <= STEP_RESET;
            cfg_reg.step_im    <= STEP_RESET;
            cfg_reg.offset_re  <= OFFSET_RESET;
            cfg_reg.offset_im  <= OFFSET_RESET;
            cfg_reg.iter_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Coordinate front end
    tce_front #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_q  (cfg_reg),
        .pixel  (pixel),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    // Job queue
    tce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Iteration engine
    tce_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_q     (cfg_reg),
        .job_valid (!q_empty),
        .job       (q_out),
        .job_pop   (q_pop),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (res),
        .busy      (eng_busy)
    );

    assign result.out_col         = res.out_col;
    assign result.out_row         = res.out_row;
    assign result.iteration_count = res.iteration_count;
    assign result.escaped         = res.escaped;

    // Queue never overflows or underflows
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full job queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty job queue");

    // A new result only appears after the engine worked on a pixel
    a_result_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(eng_busy))
        else $error("result valid without engine activity");

endmodule
